// ===== design/nrle_pkg.sv =====
package nrle_pkg;

    localparam int NIB_W      = 4;
    localparam int BYTE_W     = 8;
    localparam int WORD_NIBS  = 16;
    localparam int WORD_W     = WORD_NIBS * NIB_W;
    localparam int FILL_W     = 5;
    localparam int RUN_W      = 9;
    localparam int OUT_TDATA_W = 72;

    localparam logic [RUN_W-1:0] RUN_ZERO_MEANS = 9'h100;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NIB   = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        PH_PIXEL = 2'd0,
        PH_LOW   = 2'd1,
        PH_HIGH  = 2'd2
    } phase_t;

    typedef struct packed {
        logic             push;
        logic             clear;
        logic [NIB_W-1:0] pix;
    } pack_ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] word_with;
        logic [FILL_W-1:0] fill;
        logic              last_slot;
    } pack_stat_t;

endpackage

// ===== design/nibble_rle_row_decoder.sv =====
// Channel  Dir  Signals                    Word contents (lowest bit up)
// s_axis   in   s_tvalid s_tready s_tdata  code_byte[7:0]; s_tlast = last_of_row
// m_axis   out  m_tvalid m_tready m_tdata  packed_pixels[63:0], pixel_count[68:64], zero pad;
//                                          m_tlast = row_end
//
// Each coded byte is accepted, then its low and high nibbles are decoded in turn;
// each code it completes plays out as per-pixel nibble writes into the word packer,
// which set the rate, and the row's last byte ends in a flush. Reset clears all
// decode state at once, not the byte or output data registers. A full word waits
// in the output register; the last pixel of a word and the flush stall while held.
module nibble_rle_row_decoder #(
    parameter int PIXELS_PER_WORD = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // code_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // packed_pixels[63:0], pixel_count[68:64], zero[71:69]
    output logic        m_tlast
);
    import nrle_pkg::*;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic              sel_reg, sel_next;
    logic [BYTE_W-1:0] held_reg, held_next;
    phase_t            phase_reg, phase_next;
    logic [RUN_W-1:0]  run_reg, run_next;

    logic              ov_reg, ov_next;
    logic [WORD_W-1:0] od_reg, od_next;
    logic [FILL_W-1:0] oc_reg, oc_next;
    logic              oe_reg, oe_next;

    pack_ctrl_t        pctrl;
    pack_stat_t        pstat;
    logic [NIB_W-1:0]  nib;
    logic [BYTE_W-1:0] count_byte;
    logic              out_free;
    state_t            after_nib;

    nrle_packer #(
        .PIXELS_PER_WORD(PIXELS_PER_WORD)
    ) u_packer (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (pctrl),
        .stat (pstat)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign out_free   = !ov_reg || m_tready;
    assign nib        = sel_reg ? byte_reg[7:4] : byte_reg[3:0];
    assign count_byte = {nib, held_reg[7:4]};
    assign after_nib  = !sel_reg ? ST_NIB : (last_reg ? ST_FLUSH : ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        sel_next   = sel_reg;
        held_next  = held_reg;
        phase_next = phase_reg;
        run_next   = run_reg;
        ov_next    = ov_reg && !m_tready;
        od_next    = od_reg;
        oc_next    = oc_reg;
        oe_next    = oe_reg;
        pctrl      = '{push: 1'b0, clear: 1'b0, pix: held_reg[3:0]};

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next  = s_tdata;
                    last_next  = s_tlast;
                    sel_next   = 1'b0;
                    state_next = ST_NIB;
                end
            end
            ST_NIB:
            begin
                case (phase_reg)
                    PH_LOW:
                    begin
                        held_next  = {nib, held_reg[3:0]};
                        phase_next = PH_HIGH;
                        state_next = after_nib;
                        sel_next   = 1'b1;
                    end
                    PH_HIGH:
                    begin
                        held_next  = {held_reg[3:0], held_reg[7:4]};
                        run_next   = (count_byte == '0) ? RUN_ZERO_MEANS
                                                        : {1'b0, count_byte};
                        phase_next = PH_PIXEL;
                        state_next = ST_RUN;
                    end
                    default:
                    begin
                        held_next  = {4'h0, nib};
                        phase_next = PH_LOW;
                        state_next = after_nib;
                        sel_next   = 1'b1;
                    end
                endcase
            end
            ST_RUN:
            begin
                // held_reg[7:4] carries the pixel while the run plays out
                pctrl.pix = held_reg[7:4];
                if (!pstat.last_slot || out_free)
                begin
                    pctrl.push = 1'b1;
                    if (pstat.last_slot)
                    begin
                        ov_next = 1'b1;
                        od_next = pstat.word_with;
                        oc_next = FILL_W'(PIXELS_PER_WORD);
                        oe_next = 1'b0;
                    end
                    run_next = run_reg - RUN_W'(1);
                    if (run_reg == RUN_W'(1))
                    begin
                        held_next  = '0;
                        state_next = after_nib;
                        sel_next   = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    od_next     = pstat.word;
                    oc_next     = pstat.fill;
                    oe_next     = 1'b1;
                    pctrl.clear = 1'b1;
                    held_next   = '0;
                    phase_next  = PH_PIXEL;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            sel_reg   <= 1'b0;
            last_reg  <= 1'b0;
            held_reg  <= '0;
            phase_reg <= PH_PIXEL;
            run_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            last_reg  <= last_next;
            held_reg  <= held_next;
            phase_reg <= phase_next;
            run_reg   <= run_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        od_reg   <= od_next;
        oc_reg   <= oc_next;
        oe_reg   <= oe_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, oc_reg, od_reg};
    assign m_tlast  = oe_reg;

endmodule

// ===== design/nrle_packer.sv =====
module nrle_packer #(
    parameter int PIXELS_PER_WORD = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nrle_pkg::pack_ctrl_t ctrl,
    output nrle_pkg::pack_stat_t stat
);
    import nrle_pkg::*;

    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [WORD_W-1:0] word_with;
    logic              last_slot;

    assign last_slot = (fill_reg == FILL_W'(PIXELS_PER_WORD - 1));

    always_comb
    begin
        for (int i = 0; i < WORD_NIBS; i++)
        begin
            word_with[i*NIB_W +: NIB_W] = (fill_reg[3:0] == 4'(i)) ? ctrl.pix
                                                                    : acc_reg[i*NIB_W +: NIB_W];
        end
    end

    always_comb
    begin
        acc_next  = acc_reg;
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            acc_next  = '0;
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            if (last_slot)
            begin
                acc_next  = '0;
                fill_next = '0;
            end
            else
            begin
                acc_next  = word_with;
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
        end
    end

    assign stat.word      = acc_reg;
    assign stat.word_with = word_with;
    assign stat.fill      = fill_reg;
    assign stat.last_slot = last_slot;

endmodule
